[sv/u2u_pkg.sv]
// Shared types and constants for the UTF-8 to UTF-16 decoder.
`timescale 1ns / 1ps
`default_nettype none

package u2u_pkg;

  // Depth of the queue between the byte front end and the decode back end.
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0] LEAD2_MASK = 8'h1f;
  localparam logic [7:0] LEAD3_MASK = 8'h0f;
  localparam logic [7:0] CONT_MASK  = 8'h3f;
  localparam logic [7:0] ASCII_MAX  = 8'h7f;
  localparam logic [7:0] LEAD2_SEL  = 8'he0;
  localparam logic [7:0] LEAD2_TAG  = 8'hc0;
  localparam logic [7:0] LEAD3_SEL  = 8'hf0;
  localparam logic [7:0] LEAD3_TAG  = 8'he0;

  localparam logic [1:0] PEND_LEAD2 = 2'd1;
  localparam logic [1:0] PEND_LEAD3 = 2'd2;

  // Byte class as seen with no sequence open.
  typedef enum logic [2:0] {
    CLS_ZERO,
    CLS_ASCII,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_OTHER
  } u2u_class_e;

  typedef struct packed {
    u2u_class_e cls;
    logic [7:0] data;
  } u2u_item_t;

endpackage

`default_nettype wire

[sv/u2u_queue.sv]
// Short FIFO of classified bytes between front and back end.
`timescale 1ns / 1ps
`default_nettype none

module u2u_queue #(
  parameter int unsigned Depth = u2u_pkg::QUEUE_DEPTH
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                push_i,
  input  u2u_pkg::u2u_item_t data_i,
  output logic               full_o,
  input  wire                pop_i,
  output u2u_pkg::u2u_item_t data_o,
  output logic               empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  u2u_pkg::u2u_item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count beyond depth");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count did not grow on push");

  a_pop_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && !do_push) |=> (count_q == $past(count_q) - 1'b1))
    else $error("queue count did not shrink on pop");
`endif

endmodule

`default_nettype wire

[sv/u2u_front.sv]
// Front end: accepts input bytes, classifies them and queues them.
`timescale 1ns / 1ps
`default_nettype none

module u2u_front #(
  parameter int unsigned QueueDepth = u2u_pkg::QUEUE_DEPTH
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                push_i,
  input  wire  [7:0]         byte_in_i,
  output logic               full_o,
  output logic               item_valid_o,
  output u2u_pkg::u2u_item_t item_o,
  input  wire                item_ready_i
);

  u2u_pkg::u2u_item_t cls_item;
  logic q_empty;

  always_comb begin
    cls_item.data = byte_in_i;
    if (byte_in_i == 8'h00) begin
      cls_item.cls = u2u_pkg::CLS_ZERO;
    end else if (byte_in_i <= u2u_pkg::ASCII_MAX) begin
      cls_item.cls = u2u_pkg::CLS_ASCII;
    end else if ((byte_in_i & u2u_pkg::LEAD2_SEL) == u2u_pkg::LEAD2_TAG) begin
      cls_item.cls = u2u_pkg::CLS_LEAD2;
    end else if ((byte_in_i & u2u_pkg::LEAD3_SEL) == u2u_pkg::LEAD3_TAG) begin
      cls_item.cls = u2u_pkg::CLS_LEAD3;
    end else begin
      cls_item.cls = u2u_pkg::CLS_OTHER;
    end
  end

  u2u_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .data_i (cls_item),
    .full_o (full_o),
    .pop_i  (item_ready_i),
    .data_o (item_o),
    .empty_o(q_empty)
  );

  assign item_valid_o = !q_empty;

endmodule

`default_nettype wire

[sv/u2u_back.sv]
// Back end: sequence state, code unit assembly and the result register.
`timescale 1ns / 1ps
`default_nettype none

module u2u_back (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                item_valid_i,
  input  u2u_pkg::u2u_item_t item_i,
  output logic               item_ready_o,
  output logic               empty_o,
  input  wire                pop_i,
  output logic [15:0]        code_unit_o,
  output logic               end_of_text_o
);

  logic [1:0]  pending_q, pending_d;
  logic [11:0] partial_q, partial_d;
  logic        out_valid_q, out_valid_d;
  logic [15:0] out_unit_q;
  logic        out_eot_q;

  logic        take, emit, emit_eot;
  logic [15:0] emit_unit, acc;
  logic [5:0]  cont_bits;
  logic [1:0]  pending_dec;

  // The result register can load whenever it is free or being drained.
  assign item_ready_o = !out_valid_q || pop_i;
  assign take         = item_valid_i && item_ready_o;

  assign cont_bits   = 6'(item_i.data & u2u_pkg::CONT_MASK);
  assign acc         = {partial_q[9:0], cont_bits};
  assign pending_dec = pending_q - 1'b1;

  always_comb begin
    pending_d = pending_q;
    partial_d = partial_q;
    emit      = 1'b0;
    emit_eot  = 1'b0;
    emit_unit = '0;
    if (item_i.cls == u2u_pkg::CLS_ZERO) begin
      // Terminator, also inside a sequence: drop the partial bits.
      pending_d = '0;
      partial_d = '0;
      emit      = 1'b1;
      emit_eot  = 1'b1;
    end else if (pending_q != '0) begin
      // Any nonzero byte counts as a continuation here.
      pending_d = pending_dec;
      if (pending_dec == '0) begin
        partial_d = '0;
        emit      = 1'b1;
        emit_unit = acc;
      end else begin
        partial_d = acc[11:0];
      end
    end else begin
      case (item_i.cls)
        u2u_pkg::CLS_ASCII: begin
          emit      = 1'b1;
          emit_unit = {8'h00, item_i.data};
        end
        u2u_pkg::CLS_LEAD2: begin
          pending_d = u2u_pkg::PEND_LEAD2;
          partial_d = 12'(item_i.data & u2u_pkg::LEAD2_MASK);
        end
        u2u_pkg::CLS_LEAD3: begin
          pending_d = u2u_pkg::PEND_LEAD3;
          partial_d = 12'(item_i.data & u2u_pkg::LEAD3_MASK);
        end
        default: begin
          // Stray or unsupported lead byte: skipped.
        end
      endcase
    end
  end

  always_comb begin
    if (take) begin
      out_valid_d = emit;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= '0;
      partial_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take) begin
        pending_q <= pending_d;
        partial_q <= partial_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && emit) begin
      out_unit_q <= emit_unit;
      out_eot_q  <= emit_eot;
    end
  end

  assign empty_o       = !out_valid_q;
  assign code_unit_o   = out_unit_q;
  assign end_of_text_o = out_eot_q;

`ifndef SYNTH
  a_eot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_eot_q) |-> (out_unit_q == '0))
    else $error("terminator carries a nonzero code unit");

  a_zero_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && item_i.cls == u2u_pkg::CLS_ZERO) |=> (pending_q == '0 && partial_q == '0))
    else $error("zero byte left a sequence open");

  a_pending_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q != 2'd3)
    else $error("pending count out of range");

  a_no_take_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pop_i) |-> !take)
    else $error("result register overwritten while held");
`endif

endmodule

`default_nettype wire

[sv/utf8_to_utf16_decoder.sv]
// Top level of the UTF-8 to UTF-16 (BMP) stream decoder.
// Path: each byte is classified into the queue, then decoded into the result register once that register is free.
// Throughput: one byte per cycle while the queue is not full and the result register is free or being popped.
// Reset: rst_ni clears the queue, the result register and any open sequence at once.
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_utf16_decoder #(
  parameter int unsigned QueueDepth = u2u_pkg::QUEUE_DEPTH
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // Byte side: a transaction is push_i high while full_o is low.
  input  wire         push_i,
  input  wire  [7:0]  byte_in_i,
  output logic        full_o,
  // Result side: a transaction is pop_i high while empty_o is low.
  input  wire         pop_i,
  output logic        empty_o,
  output logic [15:0] code_unit_o,
  output logic        end_of_text_o
);

  // Classified bytes leave the front queue toward the decoder.
  logic               item_valid;
  logic               item_ready;
  u2u_pkg::u2u_item_t item;

  // Front end: classifies each byte on entry and buffers it, so the byte
  // side keeps running while the result side stalls, until the queue is full.
  u2u_front #(
    .QueueDepth(QueueDepth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .byte_in_i   (byte_in_i),
    .full_o      (full_o),
    .item_valid_o(item_valid),
    .item_o      (item),
    .item_ready_i(item_ready)
  );

  // Back end: tracks the open sequence, builds the code unit and holds
  // the oldest result until it is popped.
  u2u_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_ready_o (item_ready),
    .empty_o      (empty_o),
    .pop_i        (pop_i),
    .code_unit_o  (code_unit_o),
    .end_of_text_o(end_of_text_o)
  );

endmodule

`default_nettype wire

[dv/utf8_to_utf16_decoder_test.sv]
// Self-checking bench for the UTF-8 to UTF-16 decoder: a table of fixed bytes, then random text.
`timescale 1ns / 1ps

module utf8_to_utf16_decoder_test;

  // Byte classes and sequence lengths the predictor works with.
  localparam logic [7:0] NUL_BYTE   = 8'h00;
  localparam logic [7:0] ASCII_TOP  = 8'h7f;
  localparam logic [7:0] LEAD2_PICK = 8'he0;
  localparam logic [7:0] LEAD2_MARK = 8'hc0;
  localparam logic [7:0] LEAD3_PICK = 8'hf0;
  localparam logic [7:0] LEAD3_MARK = 8'he0;
  localparam logic [1:0] SEQ2_CONTS = 2'd1;
  localparam logic [1:0] SEQ3_CONTS = 2'd2;

  localparam int unsigned TOTAL_BYTES = 1550;
  localparam int unsigned IDLE_PCT    = 37;
  // No idling on either side while the cycle count is in this window.
  localparam int unsigned CALM_FROM   = 600;
  localparam int unsigned CALM_TO     = 1100;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_WAIT  = 8;
  localparam int unsigned PRINT_CAP   = 40;

  // One stimulus byte. Where typed is set, yields/unit/eot are the result
  // written into the table by hand and the predictor is only used to track
  // sequence state.
  typedef struct packed {
    logic [7:0]  data;
    logic        typed;
    logic        yields;
    logic [15:0] unit;
    logic        eot;
  } text_row_t;

  typedef struct packed {
    logic [15:0] unit;
    logic        eot;
  } unit_rec_t;

  // Opening table: extremes, every byte class and every odd case.
  localparam text_row_t OPENING [25] = '{
    '{8'h00, 1'b1, 1'b1, 16'h0000, 1'b1},  // terminator straight after reset
    '{8'h01, 1'b1, 1'b1, 16'h0001, 1'b0},  // smallest ASCII
    '{8'h7f, 1'b1, 1'b1, 16'h007f, 1'b0},  // largest ASCII
    '{8'h55, 1'b1, 1'b1, 16'h0055, 1'b0},
    '{8'haa, 1'b1, 1'b0, 16'h0000, 1'b0},  // stray continuation, dropped
    '{8'h80, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{8'hbf, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{8'hf0, 1'b1, 1'b0, 16'h0000, 1'b0},  // four-byte lead, unsupported
    '{8'hff, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{8'hc0, 1'b0, 1'b0, 16'h0000, 1'b0},  // overlong two-byte zero
    '{8'h80, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'hdf, 1'b0, 1'b0, 16'h0000, 1'b0},  // largest two-byte unit
    '{8'hbf, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'he0, 1'b0, 1'b0, 16'h0000, 1'b0},  // overlong three-byte zero
    '{8'h80, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'h80, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'hef, 1'b0, 1'b0, 16'h0000, 1'b0},  // largest three-byte unit
    '{8'hbf, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'hbf, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'he2, 1'b0, 1'b0, 16'h0000, 1'b0},  // zero cuts a three-byte sequence
    '{8'h00, 1'b1, 1'b1, 16'h0000, 1'b1},
    '{8'hc3, 1'b0, 1'b0, 16'h0000, 1'b0},  // fresh start, then a non-10xxxxxx tail
    '{8'h41, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'hc5, 1'b0, 1'b0, 16'h0000, 1'b0},  // zero cuts a two-byte sequence
    '{8'h00, 1'b1, 1'b1, 16'h0000, 1'b1}
  };

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        push_i        = 1'b0;
  logic [7:0]  byte_in_i     = 8'h00;
  logic        pop_i         = 1'b0;
  wire         full_o;
  wire         empty_o;
  wire  [15:0] code_unit_o;
  wire         end_of_text_o;

  text_row_t   text_bytes [$];
  unit_rec_t   units_due [$];

  // Predictor state: continuation bytes still owed and payload gathered.
  logic [1:0]  cont_left    = '0;
  logic [11:0] payload_bits = '0;

  int unsigned cyc          = 0;
  int unsigned send_idx     = 0;
  int unsigned bytes_taken  = 0;
  int unsigned units_seen   = 0;
  int unsigned ends_seen    = 0;
  int unsigned stall_cycles = 0;
  int unsigned mismatches   = 0;

  utf8_to_utf16_decoder uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push_i),
    .byte_in_i     (byte_in_i),
    .full_o        (full_o),
    .pop_i         (pop_i),
    .empty_o       (empty_o),
    .code_unit_o   (code_unit_o),
    .end_of_text_o (end_of_text_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  wire calm = (cyc >= CALM_FROM) && (cyc < CALM_TO);

  // Decode one byte; updates predictor state and returns the unit, if any.
  function automatic void decode_byte(input logic [7:0] b, output logic yields,
                                      output logic [15:0] unit, output logic eot);
    logic [15:0] merged;
    yields = 1'b0;
    unit   = '0;
    eot    = 1'b0;
    merged = {payload_bits[9:0], b[5:0]};
    if (b == NUL_BYTE) begin
      // Terminator wins over any open sequence.
      cont_left    = '0;
      payload_bits = '0;
      yields       = 1'b1;
      eot          = 1'b1;
    end else if (cont_left != '0) begin
      // Any nonzero byte counts as a continuation; only six bits are kept.
      cont_left = cont_left - 2'd1;
      if (cont_left == '0) begin
        payload_bits = '0;
        yields       = 1'b1;
        unit         = merged;
      end else begin
        payload_bits = merged[11:0];
      end
    end else if (b <= ASCII_TOP) begin
      yields = 1'b1;
      unit   = {8'h00, b};
    end else if ((b & LEAD2_PICK) == LEAD2_MARK) begin
      payload_bits = {7'b0, b[4:0]};
      cont_left    = SEQ2_CONTS;
    end else if ((b & LEAD3_PICK) == LEAD3_MARK) begin
      payload_bits = {8'b0, b[3:0]};
      cont_left    = SEQ3_CONTS;
    end
    // Stray continuations and four-byte leads fall through with no unit.
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    text_row_t r;
    r      = '0;
    r.data = b;
    text_bytes.push_back(r);
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("[%0t] unit %0d: %s got %h, want %h", $time, units_seen, what, got, want);
  endtask

  // Byte side. A byte offered while full is held until it goes through.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cyc <= cyc + 1;
      if (push_i && !full_o) send_idx = send_idx + 1;
      if (!(push_i && full_o)) begin
        if (send_idx < text_bytes.size() && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          push_i    <= 1'b1;
          byte_in_i <= text_bytes[send_idx].data;
        end else begin
          push_i <= 1'b0;
        end
      end
    end
  end

  // Result side: random back-pressure outside the calm window.
  always @(posedge clk_i) begin
    if (rst_ni) pop_i <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // Monitor: predict on every accepted byte, check every accepted unit.
  always @(posedge clk_i) begin
    text_row_t   cur;
    unit_rec_t   want;
    logic        yields;
    logic        eot;
    logic [15:0] unit;
    if (rst_ni) begin
      if (push_i && !full_o) begin
        cur = text_bytes[bytes_taken];
        decode_byte(cur.data, yields, unit, eot);
        if (cur.typed) begin
          yields = cur.yields;
          unit   = cur.unit;
          eot    = cur.eot;
        end
        if (yields) units_due.push_back('{unit, eot});
        bytes_taken++;
      end
      if (pop_i && !empty_o) begin
        units_seen++;
        if (end_of_text_o) ends_seen++;
        if (units_due.size() == 0) begin
          report_mismatch("unit with nothing due", code_unit_o, 16'h0000);
        end else begin
          want = units_due.pop_front();
          if (code_unit_o !== want.unit)
            report_mismatch("code_unit", code_unit_o, want.unit);
          if (end_of_text_o !== want.eot)
            report_mismatch("end_of_text", {15'b0, end_of_text_o}, {15'b0, want.eot});
        end
      end
    end
  end

  // Watchdog: too long without a transaction on either side ends the run.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push_i && !full_o) || (pop_i && !empty_o)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: %0d of %0d bytes taken, %0d units outstanding",
                 bytes_taken, text_bytes.size(), units_due.size());
        $display("utf8_to_utf16_decoder regression: fail");
        $finish;
      end
    end
  end

  initial begin
    int unsigned pick;
    foreach (OPENING[i]) text_bytes.push_back(OPENING[i]);
    // Random text: mostly well-formed characters, with terminators,
    // cut-off sequences and raw noise mixed in.
    while (text_bytes.size() < TOTAL_BYTES) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        add_byte(8'($urandom_range(127, 1)));
      end else if (pick < 52) begin
        add_byte({3'b110, 5'($urandom)});
        add_byte({2'b10, 6'($urandom)});
      end else if (pick < 74) begin
        add_byte({4'b1110, 4'($urandom)});
        add_byte({2'b10, 6'($urandom)});
        add_byte({2'b10, 6'($urandom)});
      end else if (pick < 80) begin
        add_byte(NUL_BYTE);
      end else if (pick < 90) begin
        // Lead byte followed by a zero or an arbitrary nonzero byte.
        add_byte($urandom_range(1) ? {3'b110, 5'($urandom)} : {4'b1110, 4'($urandom)});
        add_byte($urandom_range(1) ? NUL_BYTE : 8'($urandom_range(255, 1)));
      end else begin
        add_byte(8'($urandom));
      end
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (bytes_taken < text_bytes.size() || units_due.size() != 0) @(posedge clk_i);
    // Give a late extra unit time to show up.
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("decoded %0d bytes (%0d from the opening table) into %0d code units,",
             bytes_taken, $size(OPENING), units_seen);
    $display("%0d of them end-of-text markers; %0d mismatches", ends_seen, mismatches);
    if (mismatches == 0) begin
      $display("utf8_to_utf16_decoder regression: pass");
    end else begin
      $display("utf8_to_utf16_decoder regression: fail");
    end
    $finish;
  end

endmodule
